// ===== rtl/rrlf_pkg.sv =====
// ----------------------------------------------------------------------------
// rrlf_pkg
// Shared types and codes of the ring route learning forwarder.
// ----------------------------------------------------------------------------
package rrlf_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_HELLO = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic [1:0] ACT_DROP    = 2'd0;
  localparam logic [1:0] ACT_SEND    = 2'd1;
  localparam logic [1:0] ACT_DELIVER = 2'd2;

  localparam logic       CFG_NODE_ID  = 1'b0;
  localparam logic       CFG_SHORTEST = 1'b1;

  localparam logic [7:0] HOP_MAX = 8'hFF;

  typedef struct packed {
    logic       port;
    logic [7:0] hops;
  } rt_entry_t;

  typedef struct packed {
    logic      valid;
    rt_entry_t entry;
  } rt_rd_t;

endpackage

// ===== rtl/rrlf_route_table.sv =====
// ----------------------------------------------------------------------------
// rrlf_route_table
// Route memory with one registered read port, one write port and valid bits.
// ----------------------------------------------------------------------------
module rrlf_route_table #(
  parameter int NODES = 256,
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output rrlf_pkg::rt_rd_t   rd_data,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  rrlf_pkg::rt_entry_t wr_data
);
  import rrlf_pkg::*;

  rt_entry_t        mem [NODES];
  logic [NODES-1:0] valid_r;
  rt_entry_t        rd_entry_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data.valid = rd_valid_r;
  assign rd_data.entry = rd_entry_r;

endmodule

// ===== rtl/ring_route_learning_forwarder_top.sv =====
// ----------------------------------------------------------------------------
// ring_route_learning_forwarder_top
// Two-port ring forwarding node that learns shortest-hop routes from hellos.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Hello and data
// requests pass through the registered route table read, then a step that
// forms the result and, for a hello, writes back the learned route. A timer
// tick gives two results, port 0 first. Each result appears on the out_ ports
// for a single cycle with out_valid high and cannot be held off, so the
// receiver must take it then. Busy drops in the cycle the final result is
// shown, so a new request can be taken while it is on the ports.
// The route table needs no clearing pass after reset.
module ring_route_learning_forwarder_top #(
  parameter int NODES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_op,
  input  logic       in_arrival_port,
  input  logic [7:0] in_source,
  input  logic [7:0] in_destination,
  input  logic [7:0] in_hop_count,
  output logic       out_valid,
  output logic [1:0] out_action,
  output logic       out_port,
  output logic       out_is_hello,
  output logic [7:0] out_pkt_source,
  output logic [7:0] out_pkt_destination,
  output logic [7:0] out_new_hop_count,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  import rrlf_pkg::*;

  localparam int         IDX_W   = (NODES > 1) ? $clog2(NODES) : 1;
  localparam logic [8:0] NODES_L = 9'(NODES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_TICK2 = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [7:0] node_id_r;
  logic       use_sp_r;

  logic [1:0] req_op_r;
  logic       req_port_r;
  logic [7:0] req_src_r;
  logic [7:0] req_dst_r;
  logic [7:0] req_hops_r;

  logic       accept;
  logic [7:0] rd_id;
  rt_rd_t     rd_data;
  logic       wr_en;
  rt_entry_t  wr_data;

  logic       src_in_range;
  logic       dst_in_range;
  logic [7:0] hops_inc;

  logic       valid_nxt;
  logic [1:0] action_nxt;
  logic       port_nxt;
  logic       hello_nxt;
  logic [7:0] src_nxt;
  logic [7:0] dst_nxt;
  logic [7:0] hops_nxt;
  logic       last_nxt;

  logic       out_valid_r;
  logic [1:0] out_action_r;
  logic       out_port_r;
  logic       out_is_hello_r;
  logic [7:0] out_src_r;
  logic [7:0] out_dst_r;
  logic [7:0] out_hops_r;
  logic       out_last_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign rd_id     = (in_op == OP_HELLO) ? in_source : in_destination;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r <= 8'd0;
      use_sp_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NODE_ID:  node_id_r <= cfg_data;
        CFG_SHORTEST: use_sp_r  <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_op_r   <= in_op;
      req_port_r <= in_arrival_port;
      req_src_r  <= in_source;
      req_dst_r  <= in_destination;
      req_hops_r <= in_hop_count;
    end
  end

  rrlf_route_table #(
    .NODES (NODES),
    .IDX_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (rd_id[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (req_src_r[IDX_W-1:0]),
    .wr_data (wr_data)
  );

  assign src_in_range = ({1'b0, req_src_r} < NODES_L);
  assign dst_in_range = ({1'b0, req_dst_r} < NODES_L);
  assign hops_inc     = (req_hops_r == HOP_MAX) ? HOP_MAX : req_hops_r + 8'd1;
  assign wr_data.port = req_port_r;
  assign wr_data.hops = req_hops_r;

  always_comb begin
    state_nxt  = state_r;
    wr_en      = 1'b0;
    valid_nxt  = 1'b0;
    action_nxt = ACT_DROP;
    port_nxt   = 1'b0;
    hello_nxt  = 1'b0;
    src_nxt    = 8'd0;
    dst_nxt    = 8'd0;
    hops_nxt   = 8'd0;
    last_nxt   = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        valid_nxt = 1'b1;
        state_nxt = ST_IDLE;
        case (req_op_r)
          OP_TICK: begin
            action_nxt = ACT_SEND;
            hello_nxt  = 1'b1;
            src_nxt    = node_id_r;
            hops_nxt   = 8'd1;
            last_nxt   = 1'b0;
            state_nxt  = ST_TICK2;
          end
          OP_HELLO: begin
            if (req_src_r != node_id_r) begin
              action_nxt = ACT_SEND;
              port_nxt   = ~req_port_r;
              hello_nxt  = 1'b1;
              src_nxt    = req_src_r;
              hops_nxt   = hops_inc;
              wr_en      = src_in_range &&
                           (!rd_data.valid || (req_hops_r < rd_data.entry.hops));
            end
          end
          OP_DATA: begin
            src_nxt = req_src_r;
            dst_nxt = req_dst_r;
            if (req_dst_r == node_id_r) begin
              action_nxt = ACT_DELIVER;
              hops_nxt   = req_hops_r;
            end else begin
              action_nxt = ACT_SEND;
              port_nxt   = use_sp_r && dst_in_range && rd_data.valid &&
                           rd_data.entry.port;
              hops_nxt   = hops_inc;
            end
          end
          default: ;
        endcase
      end
      ST_TICK2: begin
        valid_nxt  = 1'b1;
        action_nxt = ACT_SEND;
        port_nxt   = 1'b1;
        hello_nxt  = 1'b1;
        src_nxt    = node_id_r;
        hops_nxt   = 8'd1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_action_r   <= action_nxt;
    out_port_r     <= port_nxt;
    out_is_hello_r <= hello_nxt;
    out_src_r      <= src_nxt;
    out_dst_r      <= dst_nxt;
    out_hops_r     <= hops_nxt;
    out_last_r     <= last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_action_r;
  assign out_port            = out_port_r;
  assign out_is_hello        = out_is_hello_r;
  assign out_pkt_source      = out_src_r;
  assign out_pkt_destination = out_dst_r;
  assign out_new_hop_count   = out_hops_r;
  assign out_last            = out_last_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("request accepted but block not busy");

  a_write_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_LOOK) && (req_op_r == OP_HELLO))
    else $error("route table written outside a hello lookup");

  a_tick_second: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK2) |=> out_valid && out_last && out_port)
    else $error("second tick hello missing");

  a_valid_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r != ST_IDLE))
    else $error("result strobe without a request in progress");

endmodule

// ===== tb/sv/tb_rrlf_check_pkg.sv =====
// ----------------------------------------------------------------------------
// tb_rrlf_check_pkg
// Scoreboard for the ring route learning forwarder. It keeps its own copy of
// the node registers and the route table, turns every accepted request into
// the forwarding decisions the node must make, and compares each decision
// shown on the result ports field by field with the oldest one still due.
// ----------------------------------------------------------------------------
package tb_rrlf_check_pkg;

  import rrlf_pkg::*;

  typedef struct packed {
    logic [1:0] action;
    logic       port;
    logic       is_hello;
    logic [7:0] src;
    logic [7:0] dst;
    logic [7:0] hops;
    logic       last;
  } fwd_result_t;

  class fwd_decision_board;
    logic [7:0]  node_id;
    logic        shortest;
    logic        route_valid [256];
    logic        route_port  [256];
    logic [7:0]  route_hops  [256];
    fwd_result_t pending_decisions [$];
    int unsigned mismatches;

    function new();
      node_id    = 8'd0;
      shortest   = 1'b0;
      mismatches = 0;
      foreach (route_valid[i]) begin
        route_valid[i] = 1'b0;
        route_port[i]  = 1'b0;
        route_hops[i]  = 8'd0;
      end
    endfunction

    function void write_reg(logic idx, logic [7:0] data);
      if (idx == CFG_NODE_ID) begin
        node_id = data;
      end else begin
        shortest = data[0];
      end
    endfunction

    function logic [7:0] bump(logic [7:0] h);
      return (h == HOP_MAX) ? HOP_MAX : h + 8'd1;
    endfunction

    function fwd_result_t decision(logic [1:0] action, logic port, logic is_hello,
                                   logic [7:0] src, logic [7:0] dst,
                                   logic [7:0] hops, logic last);
      fwd_result_t d;
      d.action   = action;
      d.port     = port;
      d.is_hello = is_hello;
      d.src      = src;
      d.dst      = dst;
      d.hops     = hops;
      d.last     = last;
      return d;
    endfunction

    function void take_request(logic [1:0] op, logic arr_port, logic [7:0] src,
                               logic [7:0] dst, logic [7:0] hops);
      logic oport;
      oport = 1'b0;
      case (op)
        OP_TICK: begin
          pending_decisions.push_back(decision(ACT_SEND, 1'b0, 1'b1, node_id, 8'd0,
                                               8'd1, 1'b0));
          pending_decisions.push_back(decision(ACT_SEND, 1'b1, 1'b1, node_id, 8'd0,
                                               8'd1, 1'b1));
        end
        OP_HELLO: begin
          if (src == node_id) begin
            pending_decisions.push_back(decision(ACT_DROP, 1'b0, 1'b0, 8'd0, 8'd0,
                                                 8'd0, 1'b1));
          end else begin
            // The table keeps the hop count as received, not the raised one.
            if (!route_valid[src] || hops < route_hops[src]) begin
              route_valid[src] = 1'b1;
              route_port[src]  = arr_port;
              route_hops[src]  = hops;
            end
            pending_decisions.push_back(decision(ACT_SEND, ~arr_port, 1'b1, src, 8'd0,
                                                 bump(hops), 1'b1));
          end
        end
        OP_DATA: begin
          if (dst == node_id) begin
            pending_decisions.push_back(decision(ACT_DELIVER, 1'b0, 1'b0, src, dst,
                                                 hops, 1'b1));
          end else begin
            if (shortest && route_valid[dst]) begin
              oport = route_port[dst];
            end
            pending_decisions.push_back(decision(ACT_SEND, oport, 1'b0, src, dst,
                                                 bump(hops), 1'b1));
          end
        end
        default: begin
          pending_decisions.push_back(decision(ACT_DROP, 1'b0, 1'b0, 8'd0, 8'd0,
                                               8'd0, 1'b1));
        end
      endcase
    endfunction

    function void compare_field(string name, longint now, logic [7:0] want,
                                logic [7:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0d ns: %s mismatch, expected %0h actual %0h", now, name, want, got);
      end
    endfunction

    function void match_result(fwd_result_t got, longint now);
      fwd_result_t want;
      if (pending_decisions.size() == 0) begin
        mismatches++;
        $display("%0d ns: unexpected result, expected none actual %h", now, got);
        return;
      end
      want = pending_decisions.pop_front();
      compare_field("action", now, 8'(want.action), 8'(got.action));
      compare_field("out_port", now, 8'(want.port), 8'(got.port));
      compare_field("is_hello", now, 8'(want.is_hello), 8'(got.is_hello));
      compare_field("pkt_source", now, want.src, got.src);
      compare_field("pkt_destination", now, want.dst, got.dst);
      compare_field("new_hop_count", now, want.hops, got.hops);
      compare_field("last", now, 8'(want.last), 8'(got.last));
    endfunction

    function int pending();
      return pending_decisions.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_ring_route_learning_forwarder_top.sv =====
// ----------------------------------------------------------------------------
// tb_ring_route_learning_forwarder_top
// Self-checking bench for the ring route learning forwarder. A short directed
// sequence covers ticks, own hellos, route learning and replacement, delivery,
// hop count saturation and the unused op. Random phases under several node
// settings then mix requests over a small pool of node ids, with random idle
// bursts on the request side except in the final phase.
// ----------------------------------------------------------------------------
module tb_ring_route_learning_forwarder_top;

  timeunit 1ns;
  timeprecision 1ps;

  import rrlf_pkg::*;
  import tb_rrlf_check_pkg::*;

  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam int         DRAIN_CYCLES    = 4;
  localparam int         PHASES          = 6;
  localparam int         ITEMS_PER_PHASE = 222;

  logic       clk;
  logic       rst_n           = 1'b0;
  logic       start           = 1'b0;
  logic       busy;
  logic [1:0] in_op           = 2'd0;
  logic       in_arrival_port = 1'b0;
  logic [7:0] in_source       = 8'd0;
  logic [7:0] in_destination  = 8'd0;
  logic [7:0] in_hop_count    = 8'd0;
  logic       out_valid;
  logic [1:0] out_action;
  logic       out_port;
  logic       out_is_hello;
  logic [7:0] out_pkt_source;
  logic [7:0] out_pkt_destination;
  logic [7:0] out_new_hop_count;
  logic       out_last;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic       cfg_index       = 1'b0;
  logic [7:0] cfg_data        = 8'd0;

  fwd_decision_board board;
  logic [7:0]        cur_node = 8'd0;
  logic [7:0]        id_base  = 8'd0;
  fwd_result_t       seen;

  ring_route_learning_forwarder_top #(
    .NODES(256)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_arrival_port    (in_arrival_port),
    .in_source          (in_source),
    .in_destination     (in_destination),
    .in_hop_count       (in_hop_count),
    .out_valid          (out_valid),
    .out_action         (out_action),
    .out_port           (out_port),
    .out_is_hello       (out_is_hello),
    .out_pkt_source     (out_pkt_source),
    .out_pkt_destination(out_pkt_destination),
    .out_new_hop_count  (out_new_hop_count),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  assign seen = {out_action, out_port, out_is_hello, out_pkt_source,
                 out_pkt_destination, out_new_hop_count, out_last};

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        board.match_result(seen, longint'($time));
      end
      if (start && !busy) begin
        board.take_request(in_op, in_arrival_port, in_source, in_destination,
                           in_hop_count);
      end
      if (cfg_valid && cfg_ready) begin
        board.write_reg(cfg_index, cfg_data);
      end
    end
  end

  task automatic send_req(input logic [1:0] op, input logic ap, input logic [7:0] src,
                          input logic [7:0] dst, input logic [7:0] hops);
    start           <= 1'b1;
    in_op           <= op;
    in_arrival_port <= ap;
    in_source       <= src;
    in_destination  <= dst;
    in_hop_count    <= hops;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    start           <= 1'b0;
    in_op           <= 2'($urandom);
    in_arrival_port <= 1'($urandom);
    in_source       <= 8'($urandom);
    in_destination  <= 8'($urandom);
    in_hop_count    <= 8'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic quiesce();
    start <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] node, input logic sp);
    quiesce();
    write_reg(CFG_NODE_ID, node);
    write_reg(CFG_SHORTEST, {7'($urandom), sp});
    cfg_valid <= 1'b0;
    cur_node = node;
  endtask

  function automatic logic [7:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return cur_node;
    if (r < 3) return 8'($urandom);
    return id_base + 8'($urandom_range(0, 15));
  endfunction

  task automatic rand_req();
    int         r;
    logic [1:0] op;
    logic [7:0] hops;
    r = $urandom_range(0, 99);
    if (r < 10) op = OP_TICK;
    else if (r < 50) op = OP_HELLO;
    else if (r < 95) op = OP_DATA;
    else op = OP_UNUSED;
    case ($urandom_range(0, 5))
      0: hops = 8'($urandom);
      1: hops = 8'd255 - 8'($urandom_range(0, 1));
      default: hops = 8'($urandom_range(0, 12));
    endcase
    send_req(op, 1'($urandom), pick_id(), pick_id(), hops);
  endtask

  initial begin
    logic [7:0] node;
    logic       sp;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_config(8'd0, 1'b0);
    send_req(OP_TICK,   1'b0, 8'hAA, 8'h55, 8'h00);
    send_req(OP_HELLO,  1'b1, 8'd0,  8'hFF, 8'd9);
    send_req(OP_HELLO,  1'b0, 8'd10, 8'd0,  8'd5);
    send_req(OP_HELLO,  1'b1, 8'd10, 8'd0,  8'd7);
    send_req(OP_HELLO,  1'b1, 8'd10, 8'd0,  8'd3);
    send_req(OP_HELLO,  1'b1, 8'd255, 8'd255, 8'd255);
    send_req(OP_HELLO,  1'b0, 8'd20, 8'hFF, 8'd0);
    send_req(OP_DATA,   1'b0, 8'd10, 8'd0,  8'd255);
    send_req(OP_DATA,   1'b1, 8'd0,  8'd10, 8'd4);
    send_req(OP_UNUSED, 1'b1, 8'hFF, 8'hFF, 8'hFF);

    set_config(8'd255, 1'b1);
    send_req(OP_TICK,   1'b1, 8'h00, 8'hFF, 8'hFF);
    send_req(OP_DATA,   1'b0, 8'd3,  8'd10, 8'd0);
    send_req(OP_DATA,   1'b1, 8'd3,  8'd20, 8'd254);
    send_req(OP_DATA,   1'b0, 8'd3,  8'd77, 8'd255);
    send_req(OP_HELLO,  1'b0, 8'd255, 8'd0, 8'd1);
    send_req(OP_DATA,   1'b1, 8'd42, 8'd255, 8'd17);
    send_req(OP_HELLO,  1'b1, 8'd0,  8'd0,  8'd0);
    send_req(OP_DATA,   1'b0, 8'd1,  8'd0,  8'd8);
    send_req(OP_UNUSED, 1'b0, 8'd0,  8'd0,  8'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      node    = (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255 : 8'($urandom);
      sp      = (ph != 1 && ph != 3);
      id_base = 8'($urandom);
      set_config(node, sp);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        rand_req();
        if (ph != PHASES - 1 && $urandom_range(0, 3) == 0) begin
          idle_gap($urandom_range(1, 12));
        end
      end
    end

    quiesce();
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
